[hw/rtl/pifb_pkg.sv]
// pifb_pkg: shared widths, command and register codes, locate struct and
// the bits-per-pixel clamp of the packed indexed frame buffer.
// No dependencies.
package pifb_pkg;

	localparam int unsigned BUFFER_BYTES_DEF    = 8192;
	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	localparam int unsigned BPP_W      = 4;
	localparam int unsigned LW_W       = 11;
	localparam int unsigned PCNT_W     = 9;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned COORD_W    = 10;
	localparam int unsigned RPOS_W     = 16;
	localparam int unsigned COLOR_W    = 32;
	localparam int unsigned SLOT_W     = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned BYTE_W     = 8;

	// x + y*width fits 22 bits, times at most 8 bits per pixel fits 26
	localparam int unsigned POS_W     = 22;
	localparam int unsigned BIT_W     = 26;
	localparam int unsigned BYTEPOS_W = BIT_W - 3;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BPP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PCNT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DFLT  = 2'd3;

	typedef struct packed {
		logic [BYTEPOS_W-1:0] first;
		logic [BYTEPOS_W-1:0] last;
		logic [2:0]           off;
		logic                 straddle;
		logic                 oor;
	} loc_t;

	// zero acts as one, anything above eight acts as eight
	function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] b);
		logic [BPP_W-1:0] r;
		r = b;
		if (b == '0)
			r = BPP_W'(1);
		else if (b > BPP_W'(8))
			r = BPP_W'(8);
		return r;
	endfunction

endpackage

[hw/rtl/pifb_ram.sv]
// pifb_ram: generic single-port synchronous RAM, read-first, registered read.
// No dependencies.
module pifb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem_q[addr] <= wdata;
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/pifb_locate.sv]
// pifb_locate: two-stage pixel address unit, position then bit offset,
// giving first and last byte, bit offset and range flag. Uses pifb_pkg.
module pifb_locate import pifb_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               load,
	input  logic               use_rpos,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [RPOS_W-1:0]  pixel_position,
	input  logic [LW_W-1:0]    line_width,
	input  logic [BPP_W-1:0]   bpp,
	output loc_t               loc
);

	logic [POS_W-1:0] prod;
	logic [POS_W-1:0] pos_s1;
	logic [BIT_W-1:0] bit0_s2;
	logic [BIT_W-1:0] bitn;

	assign prod = POS_W'(pixel_y) * POS_W'(line_width);

	always_ff @(posedge clk) begin
		if (load)
			pos_s1 <= use_rpos ? POS_W'(pixel_position) : POS_W'(pixel_x) + prod;
		bit0_s2 <= BIT_W'(pos_s1) * BIT_W'(bpp);
	end

	assign bitn         = bit0_s2 + BIT_W'(bpp) - BIT_W'(1);
	assign loc.first    = bit0_s2[BIT_W-1:3];
	assign loc.last     = bitn[BIT_W-1:3];
	assign loc.off      = bit0_s2[2:0];
	assign loc.straddle = (loc.first != loc.last);
	assign loc.oor      = (loc.last >= BYTEPOS_W'(BUFFER_BYTES));

endmodule

[hw/rtl/packed_indexed_frame_buffer_core.sv]
// packed_indexed_frame_buffer_core: top level, command sequencer around the
// pixel byte store and palette RAMs. Uses pifb_pkg, pifb_ram, pifb_locate.
//
// channel  direction  handshake            payload
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_stall    command, pixel_x, pixel_y, pixel_position,
//                                          pixel_color, palette_slot
// out      out        out_valid/out_stall  changed, stored_index, index_color, out_of_range
//
// load palette or unused command: straight to the result; read pixel: locate, byte
// reads, palette lookup; write pixel: locate, palette search with one palette RAM read
// per cycle, byte reads, byte writes; out-of-range write or read: locate, then result.
// after reset a clearing pass writes zero to every byte, with in_stall high;
// configuration writes are taken throughout.
// the next beat is taken while a result still waits under out_stall.
module packed_indexed_frame_buffer_core import pifb_pkg::*; #(
	parameter int unsigned BUFFER_BYTES    = BUFFER_BYTES_DEF,
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      command,
	input  logic [COORD_W-1:0]    pixel_x,
	input  logic [COORD_W-1:0]    pixel_y,
	input  logic [RPOS_W-1:0]     pixel_position,
	input  logic [COLOR_W-1:0]    pixel_color,
	input  logic [SLOT_W-1:0]     palette_slot,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  changed,
	output logic [IDX_W-1:0]      stored_index,
	output logic [COLOR_W-1:0]    index_color,
	output logic                  out_of_range
);

	localparam int unsigned BAW = $clog2(BUFFER_BYTES);
	localparam int unsigned PAW = $clog2(PALETTE_ENTRIES);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_LOC1     = 4'd2;
	localparam logic [3:0] S_LOC2     = 4'd3;
	localparam logic [3:0] S_SRCH     = 4'd4;
	localparam logic [3:0] S_RD_LO    = 4'd5;
	localparam logic [3:0] S_RD_HI    = 4'd6;
	localparam logic [3:0] S_RD_WAIT  = 4'd7;
	localparam logic [3:0] S_WR_LO    = 4'd8;
	localparam logic [3:0] S_WR_HI    = 4'd9;
	localparam logic [3:0] S_PAL_RD   = 4'd10;
	localparam logic [3:0] S_PAL_WAIT = 4'd11;
	localparam logic [3:0] S_DONE     = 4'd12;

	logic [3:0]            state_q;
	logic [BAW-1:0]        clr_q;

	logic [BPP_W-1:0]      bpp_q;
	logic [LW_W-1:0]       lw_q;
	logic [PCNT_W-1:0]     pcnt_q;
	logic [IDX_W-1:0]      dflt_q;

	logic [CMD_W-1:0]      cmd_q;
	logic [COLOR_W-1:0]    color_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  chg_q;
	logic                  oor_q;
	logic [BYTE_W-1:0]     lo_q;
	logic [BYTE_W-1:0]     hi_q;
	logic [COLOR_W-1:0]    icol_q;

	logic [PCNT_W-1:0]     issue_q;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	logic                  out_valid_q;
	logic                  res_changed_q;
	logic [IDX_W-1:0]      res_index_q;
	logic [COLOR_W-1:0]    res_color_q;
	logic                  res_oor_q;

	logic                  accept;
	logic                  res_load;
	logic [BPP_W-1:0]      bpp;
	logic [8:0]            one_sh;
	logic [BYTE_W-1:0]     mask8;
	logic [15:0]           mask16;
	logic [15:0]           win;
	logic [15:0]           nwin;
	logic [15:0]           shifted;
	logic [IDX_W-1:0]      rd_val;
	logic [IDX_W-1:0]      rd_val_c;
	logic [PCNT_W-1:0]     n_lim;
	logic                  hit;
	logic                  issue;
	logic                  lo_ch;
	logic                  hi_ch;
	loc_t                  loc;

	logic                  byte_en;
	logic                  byte_we;
	logic [BAW-1:0]        byte_addr;
	logic [BYTE_W-1:0]     byte_wdata;
	logic [BYTE_W-1:0]     byte_rdata;

	logic                  pal_en;
	logic                  pal_we;
	logic [PAW-1:0]        pal_addr;
	logic [COLOR_W-1:0]    pal_rdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign res_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign bpp    = eff_bpp(bpp_q);
	assign one_sh = 9'd1 << bpp;
	assign mask8  = BYTE_W'(one_sh - 9'd1);
	assign mask16 = 16'(mask8) << loc.off;
	assign win    = {hi_q, lo_q};
	assign nwin   = (win & ~mask16) | (16'(idx_q & mask8) << loc.off);
	assign lo_ch  = (nwin[7:0] != lo_q);
	assign hi_ch  = (nwin[15:8] != hi_q);

	assign shifted  = win >> loc.off;
	assign rd_val   = shifted[7:0] & mask8;
	// index above the active count reads as zero
	assign rd_val_c = ({1'b0, rd_val} > pcnt_q) ? '0 : rd_val;

	assign n_lim = (pcnt_q > PCNT_W'(PALETTE_ENTRIES)) ? PCNT_W'(PALETTE_ENTRIES) : pcnt_q;
	assign hit   = rd_valid_s1 && (pal_rdata == color_q);
	assign issue = (state_q == S_SRCH) && (issue_q < n_lim) && !hit;

	pifb_locate #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_locate (
		.clk           (clk),
		.load          (accept),
		.use_rpos      (command == CMD_READ),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_position(pixel_position),
		.line_width    (lw_q),
		.bpp           (bpp),
		.loc           (loc)
	);

	// byte store port
	always_comb begin
		byte_en    = 1'b0;
		byte_we    = 1'b0;
		byte_addr  = loc.first[BAW-1:0];
		byte_wdata = nwin[7:0];
		unique case (state_q)
			S_CLEAR: begin
				byte_en    = 1'b1;
				byte_we    = 1'b1;
				byte_addr  = clr_q;
				byte_wdata = '0;
			end
			S_RD_LO: begin
				byte_en = 1'b1;
			end
			S_RD_HI: begin
				byte_en   = loc.straddle;
				byte_addr = loc.last[BAW-1:0];
			end
			S_WR_LO: begin
				byte_en = lo_ch;
				byte_we = lo_ch;
			end
			S_WR_HI: begin
				byte_en    = loc.straddle && hi_ch;
				byte_we    = loc.straddle && hi_ch;
				byte_addr  = loc.last[BAW-1:0];
				byte_wdata = nwin[15:8];
			end
			default: begin
			end
		endcase
	end

	// palette port: load in the accept cycle, search reads, read-pixel lookup
	always_comb begin
		pal_en   = 1'b0;
		pal_we   = 1'b0;
		pal_addr = issue_q[PAW-1:0];
		if (accept && command == CMD_LOAD &&
		    {1'b0, palette_slot} < PCNT_W'(PALETTE_ENTRIES)) begin
			pal_en   = 1'b1;
			pal_we   = 1'b1;
			pal_addr = palette_slot[PAW-1:0];
		end else if (issue) begin
			pal_en = 1'b1;
		end else if (state_q == S_PAL_RD) begin
			pal_en   = ({1'b0, rd_val_c} < PCNT_W'(PALETTE_ENTRIES));
			pal_addr = rd_val_c[PAW-1:0];
		end
	end

	pifb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_BYTES)
	) u_bytes (
		.clk  (clk),
		.en   (byte_en),
		.we   (byte_we),
		.addr (byte_addr),
		.wdata(byte_wdata),
		.rdata(byte_rdata)
	);

	pifb_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.en   (pal_en),
		.we   (pal_we),
		.addr (pal_addr),
		.wdata(pixel_color),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q  <= BPP_W'(1);
			lw_q   <= LW_W'(1);
			pcnt_q <= '0;
			dflt_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BPP:  bpp_q  <= cfg_data[BPP_W-1:0];
				REG_LW:   lw_q   <= cfg_data[LW_W-1:0];
				REG_PCNT: pcnt_q <= cfg_data[PCNT_W-1:0];
				REG_DFLT: dflt_q <= cfg_data[IDX_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BAW'(1);
					if (clr_q == BAW'(BUFFER_BYTES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_WRITE || command == CMD_READ)
							state_q <= S_LOC1;
						else
							state_q <= S_DONE;
					end
				end
				S_LOC1: state_q <= S_LOC2;
				S_LOC2: begin
					if (loc.oor)
						state_q <= S_DONE;
					else if (cmd_q == CMD_WRITE)
						state_q <= S_SRCH;
					else
						state_q <= S_RD_LO;
				end
				S_SRCH: begin
					if (hit || (!rd_valid_s1 && issue_q >= n_lim))
						state_q <= S_RD_LO;
				end
				S_RD_LO:   state_q <= S_RD_HI;
				S_RD_HI:   state_q <= S_RD_WAIT;
				S_RD_WAIT: state_q <= (cmd_q == CMD_WRITE) ? S_WR_LO : S_PAL_RD;
				S_WR_LO:   state_q <= S_WR_HI;
				S_WR_HI:   state_q <= S_DONE;
				S_PAL_RD:  state_q <= S_PAL_WAIT;
				S_PAL_WAIT: state_q <= S_DONE;
				S_DONE: begin
					if (res_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item work registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			color_q <= pixel_color;
			idx_q   <= '0;
			chg_q   <= 1'b0;
			oor_q   <= 1'b0;
			icol_q  <= '0;
		end
		if (issue) begin
			issue_q   <= issue_q + PCNT_W'(1);
			rd_idx_s1 <= issue_q[IDX_W-1:0];
		end
		case (state_q)
			S_LOC2: begin
				oor_q   <= loc.oor;
				issue_q <= '0;
			end
			S_SRCH: begin
				if (hit)
					idx_q <= rd_idx_s1;
				else if (!rd_valid_s1 && issue_q >= n_lim)
					idx_q <= dflt_q;
			end
			S_RD_HI:   lo_q <= byte_rdata;
			S_RD_WAIT: hi_q <= loc.straddle ? byte_rdata : '0;
			S_WR_LO:   chg_q <= lo_ch;
			S_WR_HI:   chg_q <= chg_q || (loc.straddle && hi_ch);
			S_PAL_RD:  idx_q <= rd_val_c;
			S_PAL_WAIT: begin
				icol_q <= ({1'b0, idx_q} < PCNT_W'(PALETTE_ENTRIES)) ? pal_rdata : '0;
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_changed_q <= chg_q;
			res_index_q   <= (cmd_q == CMD_READ) ? idx_q : '0;
			res_color_q   <= icol_q;
			res_oor_q     <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign changed      = res_changed_q;
	assign stored_index = res_index_q;
	assign index_color  = res_color_q;
	assign out_of_range = res_oor_q;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE && out_valid_q))
		else $error("result overwritten while output beat still stalled");

	a_oor_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_changed_q && res_oor_q))
		else $error("out-of-range beat reports a change");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ({1'b0, res_index_q} <= pcnt_q))
		else $error("read index above palette count");

	a_hit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH && hit) |-> ({1'b0, rd_idx_s1} < n_lim))
		else $error("palette match outside active entries");

	a_byte_we: assert property (@(posedge clk) disable iff (!arst_n)
		byte_we |-> (state_q == S_CLEAR || !loc.oor))
		else $error("byte store written for out-of-range pixel");

endmodule

[tb/tb.sv]
// tb: self-checking bench for packed_indexed_frame_buffer_core; a shadow of the
// packed pixel store, the palette and the four registers predicts every output beat.
// Depends on pifb_pkg and the core RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pifb_pkg::*;

	localparam int unsigned STORE_BYTES = BUFFER_BYTES_DEF;
	localparam int unsigned PAL_SIZE    = PALETTE_ENTRIES_DEF;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic               changed;
		logic [IDX_W-1:0]   stored_index;
		logic [COLOR_W-1:0] index_color;
		logic               out_of_range;
	} pixel_report_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [CMD_W-1:0]      command        = CMD_NONE;
	logic [COORD_W-1:0]    pixel_x        = '0;
	logic [COORD_W-1:0]    pixel_y        = '0;
	logic [RPOS_W-1:0]     pixel_position = '0;
	logic [COLOR_W-1:0]    pixel_color    = '0;
	logic [SLOT_W-1:0]     palette_slot   = '0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic                  changed;
	logic [IDX_W-1:0]      stored_index;
	logic [COLOR_W-1:0]    index_color;
	logic                  out_of_range;

	// shadow of the block state
	logic [BYTE_W-1:0]  store_shadow [STORE_BYTES];
	logic [COLOR_W-1:0] palette_shadow [PAL_SIZE];
	logic [BPP_W-1:0]   bpp_reg     = BPP_W'(1);
	logic [LW_W-1:0]    width_reg   = LW_W'(1);
	logic [PCNT_W-1:0]  count_reg   = '0;
	logic [IDX_W-1:0]   default_reg = '0;

	pixel_report_t pixel_reports [$];
	int unsigned   recent_pos [$];
	int unsigned   mismatches  = 0;
	int unsigned   cycle_count = 0;
	int unsigned   out_hold    = 0;
	bit            calm        = 1'b0;

	packed_indexed_frame_buffer_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_position (pixel_position),
		.pixel_color    (pixel_color),
		.palette_slot   (palette_slot),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.changed        (changed),
		.stored_index   (stored_index),
		.index_color    (index_color),
		.out_of_range   (out_of_range)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	function automatic int unsigned pixel_bits();
		if (bpp_reg == '0)
			return 1;
		if (bpp_reg > BPP_W'(8))
			return 8;
		return bpp_reg;
	endfunction

	function automatic int unsigned gap_draw();
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	// bit span of a pixel; false once its last bit falls past the store
	function automatic bit locate_bits(input int unsigned pos, input int unsigned bits,
			output int unsigned first, output int unsigned last, output int unsigned off);
		first = (pos * bits) >> 3;
		last = (pos * bits + bits - 1) >> 3;
		off = (pos * bits) & 7;
		return last < STORE_BYTES;
	endfunction

	function automatic pixel_report_t apply_pixel_cmd(logic [CMD_W-1:0] cmd,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic [RPOS_W-1:0] rpos,
			logic [COLOR_W-1:0] color, logic [SLOT_W-1:0] slot);
		pixel_report_t rep;
		int unsigned bits, mask, pos, first, last, off, idx, searched, i;
		logic [31:0] win, nwin;
		rep = '0;
		bits = pixel_bits();
		mask = (1 << bits) - 1;
		win = '0;
		case (cmd)
		CMD_LOAD: begin
			palette_shadow[slot] = color;
		end
		CMD_WRITE: begin
			pos = x + y * width_reg;
			searched = (count_reg > PAL_SIZE) ? PAL_SIZE : count_reg;
			idx = default_reg;
			for (i = 0; i < searched; i++) begin
				if (palette_shadow[i] == color) begin
					idx = i;
					break;
				end
			end
			if (!locate_bits(pos, bits, first, last, off)) begin
				rep.out_of_range = 1'b1;
			end else begin
				win[7:0] = store_shadow[first];
				if (last != first)
					win[15:8] = store_shadow[last];
				nwin = (win & ~(mask << off)) | ((idx & mask) << off);
				if (nwin[7:0] != win[7:0]) begin
					store_shadow[first] = nwin[7:0];
					rep.changed = 1'b1;
				end
				if (last != first && nwin[15:8] != win[15:8]) begin
					store_shadow[last] = nwin[15:8];
					rep.changed = 1'b1;
				end
			end
		end
		CMD_READ: begin
			if (!locate_bits(rpos, bits, first, last, off)) begin
				rep.out_of_range = 1'b1;
			end else begin
				win[7:0] = store_shadow[first];
				if (last != first)
					win[15:8] = store_shadow[last];
				idx = (win >> off) & mask;
				if (idx > count_reg)
					idx = 0;
				// an 8-bit index always lands inside the palette
				rep.stored_index = IDX_W'(idx);
				rep.index_color = palette_shadow[idx];
			end
		end
		default: ;
		endcase
		return rep;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
	endtask

	// result side: compare each accepted beat, then draw the next stall
	always @(posedge clk) begin
		pixel_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_reports.size() == 0) begin
				note_mismatch("result beat with nothing pending", 0, 0);
			end else begin
				want = pixel_reports.pop_front();
				if (changed !== want.changed)
					note_mismatch("changed", changed, want.changed);
				if (stored_index !== want.stored_index)
					note_mismatch("stored_index", stored_index, want.stored_index);
				if (index_color !== want.index_color)
					note_mismatch("index_color", index_color, want.index_color);
				if (out_of_range !== want.out_of_range)
					note_mismatch("out_of_range", out_of_range, want.out_of_range);
			end
			out_hold = gap_draw();
		end
	end

	always @(negedge clk) begin
		if (out_hold != 0) begin
			out_stall <= 1'b1;
			out_hold--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [RPOS_W-1:0] rpos, logic [COLOR_W-1:0] color,
			logic [SLOT_W-1:0] slot);
		int unsigned gap;
		gap = gap_draw();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pixel_x <= x;
		pixel_y <= y;
		pixel_position <= rpos;
		pixel_color <= color;
		palette_slot <= slot;
		do @(posedge clk); while (in_stall);
		pixel_reports.push_back(apply_pixel_cmd(cmd, x, y, rpos, color, slot));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_reports.size() != 0)
			@(posedge clk);
	endtask

	// junk goes into the data bits above each register
	task automatic write_reg(logic [CFG_IDX_W-1:0] which, int unsigned value);
		logic [CFG_DATA_W-1:0] data;
		data = $urandom_range(0, 2047);
		case (which)
		REG_BPP:  data[BPP_W-1:0] = BPP_W'(value);
		REG_LW:   data = LW_W'(value);
		REG_PCNT: data[PCNT_W-1:0] = PCNT_W'(value);
		REG_DFLT: data[IDX_W-1:0] = IDX_W'(value);
		endcase
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (which)
		REG_BPP:  bpp_reg = data[BPP_W-1:0];
		REG_LW:   width_reg = data;
		REG_PCNT: count_reg = data[PCNT_W-1:0];
		REG_DFLT: default_reg = data[IDX_W-1:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(int unsigned bpp, int unsigned lw, int unsigned pcnt,
			int unsigned dflt);
		drain();
		write_reg(REG_BPP, bpp);
		write_reg(REG_LW, lw);
		write_reg(REG_PCNT, pcnt);
		write_reg(REG_DFLT, dflt);
	endtask

	// every slot gets a color before any search or read can touch it
	task automatic test_palette_fill();
		int unsigned s;
		logic [COLOR_W-1:0] color;
		for (s = 0; s < PAL_SIZE; s++) begin
			color = $urandom;
			if (s == 0)
				color = '0;
			if (s == PAL_SIZE - 1)
				color = '1;
			if (s == 5)
				color = palette_shadow[2];
			send_item(CMD_LOAD, $urandom, $urandom, $urandom, color, s);
		end
	endtask

	task automatic test_commands();
		set_config(3, 5, 4, 7);
		send_item(CMD_WRITE, 0, 0, $urandom, palette_shadow[1], $urandom);
		// slot 5 repeats slot 2 but lies outside the count of four, so slot 2 is found
		send_item(CMD_WRITE, 1, 0, $urandom, palette_shadow[5], $urandom);
		// no match: default index, pixel straddles bytes 0 and 1
		send_item(CMD_WRITE, 2, 0, $urandom, $urandom, $urandom);
		send_item(CMD_WRITE, 3, 0, $urandom, palette_shadow[3], $urandom);
		send_item(CMD_WRITE, 3, 0, $urandom, palette_shadow[3], $urandom);
		send_item(CMD_READ, $urandom, $urandom, 0, $urandom, $urandom);
		send_item(CMD_READ, $urandom, $urandom, 1, $urandom, $urandom);
		send_item(CMD_READ, $urandom, $urandom, 2, $urandom, $urandom);
		send_item(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, 3);
		send_item(CMD_READ, $urandom, $urandom, 3, $urandom, $urandom);
		send_item(CMD_WRITE, 1023, 1023, $urandom, $urandom, $urandom);
		send_item(CMD_READ, $urandom, $urandom, 16'hffff, $urandom, $urandom);
		send_item(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// stored index equal to and above the palette count
	task automatic test_count_edges();
		set_config(2, 0, 4, 3);
		send_item(CMD_WRITE, 10, $urandom, $urandom, palette_shadow[2], $urandom);
		send_item(CMD_WRITE, 11, $urandom, $urandom, $urandom, $urandom);
		drain();
		write_reg(REG_PCNT, 2);
		send_item(CMD_READ, $urandom, $urandom, 10, $urandom, $urandom);
		send_item(CMD_READ, $urandom, $urandom, 11, $urandom, $urandom);
	endtask

	task automatic test_bpp_extremes();
		// zero width acts as one bit, default index keeps only its low bit
		set_config(0, 2047, 511, 255);
		send_item(CMD_WRITE, 1023, 3, $urandom, $urandom, $urandom);
		send_item(CMD_READ, $urandom, $urandom, 7164, $urandom, $urandom);
		send_item(CMD_WRITE, 1023, 1023, $urandom, $urandom, $urandom);
		send_item(CMD_READ, $urandom, $urandom, 16'hffff, $urandom, $urandom);
		// fifteen acts as eight: last byte of the store, then one past it
		set_config(15, 1024, 256, 0);
		send_item(CMD_WRITE, 1023, 7, $urandom, palette_shadow[PAL_SIZE - 1], $urandom);
		send_item(CMD_READ, $urandom, $urandom, 8191, $urandom, $urandom);
		send_item(CMD_WRITE, 0, 8, $urandom, $urandom, $urandom);
		send_item(CMD_READ, $urandom, $urandom, 8192, $urandom, $urandom);
	endtask

	task automatic random_phase(int unsigned bpp, int unsigned lw, int unsigned pcnt,
			int unsigned dflt, int unsigned n_items, bit quiet);
		int unsigned k, pick, pixels, searched, pos, x, y;
		logic [COLOR_W-1:0] color;
		set_config(bpp, lw, pcnt, dflt);
		calm = quiet;
		recent_pos.delete();
		pixels = (STORE_BYTES * 8) / pixel_bits();
		if (pixels > 65536)
			pixels = 65536;
		searched = (count_reg > PAL_SIZE) ? PAL_SIZE : count_reg;
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// copy another slot now and then so searches meet duplicates
				color = $urandom;
				if ($urandom_range(0, 1) != 0)
					color = palette_shadow[$urandom_range(0, PAL_SIZE - 1)];
				send_item(CMD_LOAD, $urandom, $urandom, $urandom, color, $urandom);
			end else if (pick < 55) begin
				pos = $urandom_range(0, pixels - 1);
				if (width_reg == 0) begin
					x = pos % 1024;
					y = $urandom_range(0, 1023);
				end else begin
					y = pos / width_reg;
					x = pos % width_reg;
				end
				if (x > 1023 || y > 1023 || $urandom_range(0, 6) == 0) begin
					x = $urandom_range(0, 1023);
					y = $urandom_range(0, 1023);
				end
				pick = $urandom_range(0, 99);
				if (pick < 55 && searched != 0)
					color = palette_shadow[$urandom_range(0, searched - 1)];
				else if (pick < 80)
					color = palette_shadow[$urandom_range(0, PAL_SIZE - 1)];
				else
					color = $urandom;
				pos = x + y * width_reg;
				if (pos < 65536) begin
					recent_pos.push_back(pos);
					if (recent_pos.size() > 32)
						void'(recent_pos.pop_front());
				end
				send_item(CMD_WRITE, x, y, $urandom, color, $urandom);
			end else if (pick < 93) begin
				// mostly read back what was just drawn
				if (recent_pos.size() != 0 && $urandom_range(0, 3) != 0)
					pos = recent_pos[$urandom_range(0, recent_pos.size() - 1)];
				else
					pos = $urandom_range(0, 65535);
				send_item(CMD_READ, $urandom, $urandom, pos, $urandom, $urandom);
			end else begin
				send_item(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end
		calm = 1'b0;
	endtask

	task automatic test_random();
		random_phase(1, 1024, 2, 0, 75, 1'b0);
		random_phase(8, 64, 256, 255, 75, 1'b0);
		random_phase(2, 100, 4, 3, 75, 1'b1);
		random_phase(4, 1024, 16, 15, 75, 1'b0);
		random_phase(3, 37, 5, 7, 75, 1'b0);
		random_phase(0, 512, 1, 1, 75, 1'b0);
		random_phase(15, 2047, 511, 200, 75, 1'b1);
		random_phase(5, 0, 32, 31, 75, 1'b0);
		random_phase(7, 333, 128, 127, 75, 1'b0);
		random_phase($urandom_range(0, 15), $urandom_range(0, 2047),
			$urandom_range(0, 511), $urandom_range(0, 255), 75, 1'b0);
		random_phase($urandom_range(1, 8), $urandom_range(1, 200),
			$urandom_range(0, 40), $urandom_range(0, 255), 75, 1'b0);
	endtask

	initial begin
		foreach (store_shadow[i])
			store_shadow[i] = '0;
		foreach (palette_shadow[i])
			palette_shadow[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_palette_fill();
		test_commands();
		test_count_edges();
		test_bpp_extremes();
		test_random();
		drain();
		// a write with a full palette search is the longest operation
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/pifb_pkg.sv
hw/rtl/pifb_ram.sv
hw/rtl/pifb_locate.sv
hw/rtl/packed_indexed_frame_buffer_core.sv
tb/tb.sv
